// ===== hdl/shsq_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package shsq_pkg;

  localparam int unsigned CODE_W  = 8;
  localparam int unsigned IVL_W   = 32;
  localparam int unsigned ATT_W   = 8;
  localparam int unsigned COUNT_W = 9;

  localparam logic [CODE_W-1:0]  CODE_OK      = 8'd0;
  localparam logic [CODE_W-1:0]  CODE_WARNING = 8'd2;
  localparam logic [COUNT_W-1:0] COUNT_MAX    = 9'd511;

  // Register indexes on the configuration port (word address).
  localparam logic [1:0] REG_NORMAL_INTERVAL = 2'd0;
  localparam logic [1:0] REG_RETRY_INTERVAL  = 2'd1;
  localparam logic [1:0] REG_ATTEMPT_LIMIT   = 2'd2;

  localparam logic [IVL_W-1:0] NORMAL_INTERVAL_RESET = 32'd18000000;
  localparam logic [IVL_W-1:0] RETRY_INTERVAL_RESET  = 32'd60000;
  localparam logic [ATT_W-1:0] ATTEMPT_LIMIT_RESET   = 8'd0;

  typedef struct packed {
    logic [IVL_W-1:0] normal_interval;
    logic [IVL_W-1:0] retry_interval;
    logic [ATT_W-1:0] attempt_limit;
  } cfg_t;

  typedef struct packed {
    logic             is_transient;
    logic [IVL_W-1:0] recheck_interval;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/shsq_regs.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shsq_regs (
  input  wire logic         clk,
  input  wire logic         rst,
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  output shsq_pkg::cfg_t    cfg
);

  logic       wr_en;
  logic [1:0] reg_idx;

  assign pready  = 1'b1;
  assign reg_idx = paddr[3:2];
  assign wr_en   = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.normal_interval <= shsq_pkg::NORMAL_INTERVAL_RESET;
      cfg.retry_interval  <= shsq_pkg::RETRY_INTERVAL_RESET;
      cfg.attempt_limit   <= shsq_pkg::ATTEMPT_LIMIT_RESET;
    end else if (wr_en) begin
      case (reg_idx)
        shsq_pkg::REG_NORMAL_INTERVAL: cfg.normal_interval <= pwdata;
        shsq_pkg::REG_RETRY_INTERVAL:  cfg.retry_interval  <= pwdata;
        shsq_pkg::REG_ATTEMPT_LIMIT:   cfg.attempt_limit   <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      shsq_pkg::REG_NORMAL_INTERVAL: prdata = cfg.normal_interval;
      shsq_pkg::REG_RETRY_INTERVAL:  prdata = cfg.retry_interval;
      shsq_pkg::REG_ATTEMPT_LIMIT:   prdata = {24'd0, cfg.attempt_limit};
      default:                       prdata = 32'd0;
    endcase
  end

endmodule

`default_nettype wire

// ===== hdl/shsq_core.sv =====
`timescale 1ns / 1ps
`default_nettype none

module shsq_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire shsq_pkg::cfg_t                cfg,
  input  wire logic                          step,
  input  wire logic [shsq_pkg::CODE_W-1:0]   code,
  output shsq_pkg::result_t                  res
);

  logic                           seen_any, seen_any_next;
  logic                           last_transient, last_transient_next;
  logic                           last_ok, last_ok_next;
  logic [shsq_pkg::COUNT_W-1:0]   retry_count, retry_count_next;
  logic                           ok;
  logic                           below;
  logic                           trans;
  logic                           use_retry;

  assign ok    = (code == shsq_pkg::CODE_OK);
  assign below = retry_count < {1'b0, cfg.attempt_limit};

  always_comb begin
    trans            = 1'b0;
    use_retry        = 1'b0;
    retry_count_next = retry_count;
    if (!seen_any) begin
      // first word: only a warning starts out soft
      trans     = (code == shsq_pkg::CODE_WARNING);
      use_retry = trans;
    end else if (!last_transient && last_ok) begin
      trans            = !ok;
      use_retry        = !ok;
      retry_count_next = '0;
    end else if (last_transient && last_ok) begin
      trans = !ok;
      if (ok) begin
        retry_count_next = '0;
      end
    end else if (!last_transient) begin
      trans = 1'b0;
    end else begin
      if (ok) begin
        trans     = 1'b1;
        use_retry = 1'b1;
      end else begin
        // compare first, then bump the counter (saturating)
        trans     = below;
        use_retry = below;
        if (retry_count != shsq_pkg::COUNT_MAX) begin
          retry_count_next = retry_count + 1'b1;
        end
      end
    end
  end

  assign seen_any_next       = 1'b1;
  assign last_transient_next = trans;
  assign last_ok_next        = ok;

  assign res.is_transient     = trans;
  assign res.recheck_interval = use_retry ? cfg.retry_interval : cfg.normal_interval;

  always_ff @(posedge clk) begin
    if (rst) begin
      seen_any       <= 1'b0;
      last_transient <= 1'b0;
      last_ok        <= 1'b1;
      retry_count    <= '0;
    end else if (step) begin
      seen_any       <= seen_any_next;
      last_transient <= last_transient_next;
      last_ok        <= last_ok_next;
      retry_count    <= retry_count_next;
    end
  end

  a_seen_after_step: assert property (@(posedge clk) disable iff (rst)
    step |=> seen_any)
    else $error("seen_any low after a processed word");

  a_hold_when_idle: assert property (@(posedge clk) disable iff (rst)
    !step |=> $stable({seen_any, last_transient, last_ok, retry_count}))
    else $error("qualifier state moved without a word");

  a_count_monotonic: assert property (@(posedge clk) disable iff (rst)
    step |=> (retry_count == '0) || (retry_count >= $past(retry_count)))
    else $error("retry counter moved backward without clearing");

  a_count_only_when_soft: assert property (@(posedge clk) disable iff (rst)
    (step && !(seen_any && last_transient && !last_ok && !ok))
      |=> (retry_count == '0) || $stable(retry_count))
    else $error("retry counter advanced outside a soft non-OK retry");

endmodule

`default_nettype wire

// ===== hdl/soft_hard_status_qualifier_top.sv =====
`timescale 1ns / 1ps
`default_nettype none

// Path: a word accepted into the input register is qualified as it moves on
//   into the result register, which presents it under out_valid.
// Throughput: one word per cycle while out_stall is low; the input register and
//   the result register let a new word enter while a finished result waits under out_stall.
// Reset (rst, synchronous, active high): pipeline empty, no status seen,
//   last status permanent OK, retry counter zero, registers at defaults.
module soft_hard_status_qualifier_top (
  input  wire logic         clk,
  input  wire logic         rst,
  // configuration port
  input  wire logic         psel,
  input  wire logic         penable,
  input  wire logic         pwrite,
  input  wire logic [3:0]   paddr,
  input  wire logic [31:0]  pwdata,
  output logic [31:0]       prdata,
  output logic              pready,
  // status words in
  input  wire logic         in_valid,
  output logic              in_stall,
  input  wire logic [7:0]   status_code,
  // qualified words out
  output logic              out_valid,
  input  wire logic         out_stall,
  output logic              is_transient,
  output logic [31:0]       recheck_interval
);

  shsq_pkg::cfg_t    cfg;
  shsq_pkg::result_t res;

  // Input register: holds one status word ahead of the qualifier.
  logic                         in_reg_valid;
  logic [shsq_pkg::CODE_W-1:0]  in_reg_code;
  logic                         advance;
  logic                         in_take;

  // Advance the input register into the result register whenever the
  // result register is empty or its word leaves this cycle.
  assign advance  = in_reg_valid && (!out_valid || !out_stall);
  assign in_stall = in_reg_valid && !advance;
  assign in_take  = in_valid && !in_stall;

  shsq_regs u_regs (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // The qualifier updates its history exactly when a word moves forward.
  shsq_core u_core (
    .clk  (clk),
    .rst  (rst),
    .cfg  (cfg),
    .step (advance),
    .code (in_reg_code),
    .res  (res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_reg_valid <= 1'b0;
    end else if (in_take) begin
      in_reg_valid <= 1'b1;
    end else if (advance) begin
      in_reg_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      in_reg_code <= status_code;
    end
  end

  // Result register: drop the word once taken, hold it while stalled.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (advance) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      is_transient     <= res.is_transient;
      recheck_interval <= res.recheck_interval;
    end
  end

endmodule

`default_nettype wire
